// ===== hdl/ftffi_pkg.sv =====
// Package: request/response types, status codes and default sizes for the flow table insert.
`default_nettype none

package ftffi_pkg;

  // Default table geometry
  localparam int unsigned BUCKET_COUNT_DEF = 1024;
  localparam int unsigned SLOTS_DEF        = 5;

  // Only the low 16 bits of the AND hash can be nonzero (ports are 16 bits)
  localparam int unsigned HASH_W       = 16;
  localparam int unsigned BUCKET_OUT_W = 10;
  localparam int unsigned SLOT_OUT_W   = 3;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_BYPASS   = 2'd2
  } status_e;

  // One connection tuple
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } flow_req_t;

  // One insert result
  typedef struct packed {
    status_e                   status;
    logic [BUCKET_OUT_W-1:0]   bucket_index;
    logic [SLOT_OUT_W-1:0]     slot_index;
  } flow_rsp_t;

  // One stored flow entry: key plus port
  typedef struct packed {
    flow_req_t   key;
    logic [15:0] port;
  } flow_entry_t;

endpackage

`default_nettype wire

// ===== hdl/flow_table_first_free_insert.sv =====
// Top level: bucketed flow table, first-free-slot insert.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------
//  in      | in        | in_valid_i / in_ready_o    | in_req_i  (flow_req_t)
//  out     | out       | out_valid_o / out_ready_i  | out_rsp_o (flow_rsp_t)
//  cfg     | in        | cfg_we_i (no wait)         | cfg_wdata_i (enable)
//
// One request per cycle while the output is not stalled; the occupancy row is read
// into the lookup stage as a request is taken, then the first-free pick and write back
// go into the output register, which presents the result.
// Back-to-back requests to the same bucket use the forwarded row.
// After reset the occupancy memory is swept, with in_ready_o low throughout the sweep.
// A stalled output holds the lookup stage, which in turn holds in_ready_o low.
`default_nettype none

module flow_table_first_free_insert #(
  parameter int unsigned BUCKET_COUNT = ftffi_pkg::BUCKET_COUNT_DEF,
  parameter int unsigned SLOTS        = ftffi_pkg::SLOTS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire ftffi_pkg::flow_req_t in_req_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output ftffi_pkg::flow_rsp_t      out_rsp_o
);

  localparam int unsigned BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned HW = ftffi_pkg::HASH_W;

  logic                  enable_q;
  logic                  clr_busy;
  logic                  in_fire;

  logic [HW-1:0]         hash_and;
  logic [HW-1:0]         hash_mask;
  logic [BW-1:0]         in_bucket;

  // Lookup stage
  logic                  s1_valid_q;
  logic                  s1_en_q;
  logic [BW-1:0]         s1_bucket_q;
  ftffi_pkg::flow_req_t  s1_key_q;
  logic                  fwd_q;
  logic [SLOTS-1:0]      fwd_row_q;
  logic                  s1_adv;
  logic [SLOTS-1:0]      rd_row;
  logic [SLOTS-1:0]      row;
  logic [SLOTS-1:0]      new_row;
  logic                  found;
  logic [SW-1:0]         slot;
  logic                  wr_en;
  logic                  fwd_hit;

  // Output register
  logic                  out_valid_q;
  ftffi_pkg::flow_rsp_t  out_q;
  ftffi_pkg::flow_rsp_t  rsp_d;
  logic [HW-1:0]         bucket_wide;
  logic [HW-1:0]         slot_wide;

  ftffi_pkg::flow_entry_t entry;

  // Enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  // Hash: AND of all fields, masked to the table size
  assign hash_and  = in_req_i.src_addr[HW-1:0] & in_req_i.dst_addr[HW-1:0]
                   & in_req_i.src_port & in_req_i.dst_port;
  assign hash_mask = HW'(BUCKET_COUNT - 1);
  always_comb begin
    logic [HW-1:0] masked;
    masked    = hash_and & hash_mask;
    in_bucket = masked[BW-1:0];
  end

  // Handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_busy && (!s1_valid_q || s1_adv);
  assign in_fire    = in_valid_i && in_ready_o;

  ftffi_occ_mem #(
    .BUCKET_COUNT (BUCKET_COUNT),
    .SLOTS        (SLOTS)
  ) u_occ_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_fire),
    .rd_addr_i  (in_bucket),
    .rd_row_o   (rd_row),
    .wr_en_i    (wr_en),
    .wr_addr_i  (s1_bucket_q),
    .wr_row_i   (new_row),
    .clr_busy_o (clr_busy)
  );

  // Row seen by the lookup: forwarded when the previous request hit the same bucket
  assign row = fwd_q ? fwd_row_q : rd_row;

  ftffi_slot_pick #(
    .SLOTS (SLOTS)
  ) u_slot_pick (
    .row_i   (row),
    .found_o (found),
    .slot_o  (slot)
  );

  // Modify: an all-zero key leaves the slot free
  assign wr_en = s1_adv && s1_en_q && found;
  always_comb begin
    new_row = row;
    if (s1_en_q && found) begin
      new_row[slot] = |s1_key_q;
    end
  end

  assign fwd_hit = in_fire && s1_adv && (in_bucket == s1_bucket_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_en_q     <= enable_q;
      s1_bucket_q <= in_bucket;
      s1_key_q    <= in_req_i;
      fwd_q       <= fwd_hit;
      fwd_row_q   <= new_row;
    end
  end

  // Entry store
  assign entry.key  = s1_key_q;
  assign entry.port = s1_key_q.dst_port;

  ftffi_key_mem #(
    .BUCKET_COUNT (BUCKET_COUNT),
    .SLOTS        (SLOTS)
  ) u_key_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .bucket_i (s1_bucket_q),
    .slot_i   (slot),
    .entry_i  (entry)
  );

  // Result
  assign bucket_wide = HW'(s1_bucket_q);
  assign slot_wide   = HW'(slot);
  always_comb begin
    rsp_d.status       = ftffi_pkg::ST_FULL;
    rsp_d.bucket_index = bucket_wide[ftffi_pkg::BUCKET_OUT_W-1:0];
    rsp_d.slot_index   = '0;
    if (!s1_en_q) begin
      rsp_d.status       = ftffi_pkg::ST_BYPASS;
      rsp_d.bucket_index = '0;
    end else if (found) begin
      rsp_d.status     = ftffi_pkg::ST_INSERTED;
      rsp_d.slot_index = slot_wide[ftffi_pkg::SLOT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> s1_valid_q && s1_en_q && !clr_busy)
    else $error("table write outside an enabled lookup");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_en_q && !found |-> (&row))
    else $error("bucket reported full with a free slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == ftffi_pkg::ST_BYPASS)
    |-> (out_rsp_o.bucket_index == '0) && (out_rsp_o.slot_index == '0))
    else $error("bypass result carries nonzero indexes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !in_ready_o && !s1_valid_q)
    else $error("request taken during occupancy sweep");

endmodule

`default_nettype wire

// ===== hdl/ftffi_occ_mem.sv =====
// Per-bucket slot occupancy memory with a clearing pass after reset.
`default_nettype none

module ftffi_occ_mem #(
  parameter int unsigned BUCKET_COUNT = ftffi_pkg::BUCKET_COUNT_DEF,
  parameter int unsigned SLOTS        = ftffi_pkg::SLOTS_DEF,
  localparam int unsigned BW          = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [BW-1:0]    rd_addr_i,
  output logic      [SLOTS-1:0] rd_row_o,
  input  wire logic             wr_en_i,
  input  wire logic [BW-1:0]    wr_addr_i,
  input  wire logic [SLOTS-1:0] wr_row_i,
  output logic                  clr_busy_o
);

  logic [SLOTS-1:0] mem [BUCKET_COUNT];
  logic [SLOTS-1:0] rd_row_q;
  logic             clr_busy_q, clr_busy_d;
  logic [BW-1:0]    clr_addr_q, clr_addr_d;

  // Clearing sweep, one row per cycle
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + BW'(1);
      if (clr_addr_q == BW'(BUCKET_COUNT - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Write port: sweep has priority, no requests are taken during it
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_row_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_row_q <= mem[rd_addr_i];
    end
  end

  assign rd_row_o   = rd_row_q;
  assign clr_busy_o = clr_busy_q;

endmodule

`default_nettype wire

// ===== hdl/ftffi_key_mem.sv =====
// Flow entry store: key and port of each slot, written on insert.
`default_nettype none

module ftffi_key_mem #(
  parameter int unsigned BUCKET_COUNT = ftffi_pkg::BUCKET_COUNT_DEF,
  parameter int unsigned SLOTS        = ftffi_pkg::SLOTS_DEF,
  localparam int unsigned BW          = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1,
  localparam int unsigned SW          = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   wr_en_i,
  input  wire logic [BW-1:0]          bucket_i,
  input  wire logic [SW-1:0]          slot_i,
  input  wire ftffi_pkg::flow_entry_t entry_i
);

  localparam int unsigned ENTRIES = BUCKET_COUNT * SLOTS;
  localparam int unsigned EW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  ftffi_pkg::flow_entry_t mem [ENTRIES];
  logic [EW-1:0]          addr;

  // Flat entry address: bucket * SLOTS + slot
  assign addr = EW'(bucket_i) * EW'(SLOTS) + EW'(slot_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ftffi_slot_pick.sv =====
// First-free slot search over one bucket's occupancy row.
`default_nettype none

module ftffi_slot_pick #(
  parameter int unsigned SLOTS = ftffi_pkg::SLOTS_DEF,
  localparam int unsigned SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic [SLOTS-1:0] row_i,
  output logic                  found_o,
  output logic      [SW-1:0]    slot_o
);

  // Priority encode: lowest free slot wins
  always_comb begin
    found_o = 1'b0;
    slot_o  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!row_i[i]) begin
        found_o = 1'b1;
        slot_o  = SW'(i);
      end
    end
  end

endmodule

`default_nettype wire
